[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clk edge outside reset
`define ECFL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition that must never be seen outside reset
`define ECFL_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[rtl/ecfl_pkg.sv]
package ecfl_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic [18:0] ONE_FX = 19'h10000;
    localparam logic [31:0] CFL_MAX = 32'hFFFF_FFFF;

    // quotient / root bits per chain, one per cell
    localparam int KE_LEN  = 31;
    localparam int C2_LEN  = 53;
    localparam int SQ_LEN  = 35;
    localparam int VEL_LEN = 48;
    localparam int CFL_LEN = 32;
    // registers outside the chains: input, square, product, pressure,
    // wave speed, partial products, dividend, output
    localparam int GLUE_REGS = 8;
    localparam int LATENCY = GLUE_REGS + KE_LEN + C2_LEN + SQ_LEN + VEL_LEN + CFL_LEN;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_BAD = 2'd2
    } status_t;

    typedef struct packed {
        logic [30:0]        density;
        logic signed [31:0] momentum;
        logic signed [31:0] energy;
        logic [18:0]        heat_ratio;
        logic signed [31:0] x_left;
        logic signed [31:0] x_here;
        logic signed [31:0] x_right;
    } cell_in_t;

    typedef struct packed {
        logic [31:0] cfl;
        status_t     status;
    } result_t;

    typedef struct packed {
        logic [30:0]        rho;
        logic [31:0]        am;
        logic signed [31:0] energy;
        logic [18:0]        gamma;
        logic [31:0]        dx;
        logic               bad;
        logic               ke_big;
    } ke_side_t;

    typedef struct packed {
        logic [30:0] rho;
        logic [31:0] am;
        logic [31:0] dx;
        logic        bad;
    } c2_side_t;

    typedef struct packed {
        logic [34:0] snd;
        logic [31:0] dx;
        logic        bad;
    } vel_side_t;

    typedef struct packed {
        logic sat;
        logic bad;
    } cfl_side_t;

endpackage

[rtl/ecfl_div_cell.sv]
// one restoring division step; quotient bits fill the freed low end of num
module ecfl_div_cell #(
    parameter int DEN_W  = 32,
    parameter int NUM_W  = 31,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [DEN_W-1:0]  in_rem,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_vld,
    output logic [DEN_W-1:0]  out_rem,
    output logic [NUM_W-1:0]  out_num,
    output logic [DEN_W-1:0]  out_den,
    output logic [SIDE_W-1:0] out_side
);

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic              vld_reg;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  den_reg;
    logic [SIDE_W-1:0] side_reg;

    always_comb
    begin
        trial    = {in_rem, in_num[NUM_W-1]};
        diff     = trial - {1'b0, in_den};
        ge       = (trial >= {1'b0, in_den});
        rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_next = {in_num[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        den_reg  <= in_den;
        side_reg <= in_side;
    end

    assign out_vld  = vld_reg;
    assign out_rem  = rem_reg;
    assign out_num  = num_reg;
    assign out_den  = den_reg;
    assign out_side = side_reg;

endmodule

[rtl/ecfl_sqrt_cell.sv]
// one digit-by-digit square root step, two operand bits per cell
module ecfl_sqrt_cell #(
    parameter int OP_W   = 70,
    parameter int ROOT_W = 35,
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  logic [ROOT_W+1:0]   in_rem,
    input  logic [OP_W-1:0]     in_op,
    input  logic [ROOT_W-1:0]   in_root,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_vld,
    output logic [ROOT_W+1:0]   out_rem,
    output logic [OP_W-1:0]     out_op,
    output logic [ROOT_W-1:0]   out_root,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int REM_W = ROOT_W + 2;

    logic [REM_W+1:0]  t;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;
    logic              vld_reg;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [SIDE_W-1:0] side_reg;

    always_comb
    begin
        t         = {in_rem, in_op[OP_W-1 -: 2]};
        trial     = {2'b00, in_root, 2'b01};
        diff      = t - trial;
        ge        = (t >= trial);
        rem_next  = ge ? diff[REM_W-1:0] : t[REM_W-1:0];
        op_next   = {in_op[OP_W-3:0], 2'b00};
        root_next = {in_root[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        op_reg   <= op_next;
        root_reg <= root_next;
        side_reg <= in_side;
    end

    assign out_vld  = vld_reg;
    assign out_rem  = rem_reg;
    assign out_op   = op_reg;
    assign out_root = root_reg;
    assign out_side = side_reg;

endmodule

[rtl/euler_cell_cfl_number.sv]
// cfl number of one cell of a 1-d euler grid, unsigned q16.16 result
//
// item in: start high with busy low accepts cell_data (conserved variables,
//   heat ratio, coordinates of the point and its two neighbors). busy is
//   always low: one item can enter on every clock cycle.
// item out: done pulses for one cycle with result (cfl, status). results of
//   items leave in accept order. the receiver cannot stall, and nothing
//   here waits for it.
// throughput: one item per cycle. the pipeline is made of chains of cells:
//   kinetic energy divide 31, sound speed squared divide 53, square root 35,
//   velocity divide 48, final divide 32, plus 8 registers outside the chains.
// config: cfg_valid/cfg_ready write time_step (cfg_ready is always high);
//   write it only while no item is in flight.
// reset: rst_n clears time_step and all valid bits; the pipeline is empty
//   and done stays low until items arrive.
module euler_cell_cfl_number (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ecfl_pkg::cell_in_t cell_data,
    output logic               done,
    output ecfl_pkg::result_t  result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);

    localparam int KA_SW = $bits(ecfl_pkg::ke_side_t);
    localparam int CB_SW = $bits(ecfl_pkg::c2_side_t);
    localparam int VC_SW = $bits(ecfl_pkg::vel_side_t);
    localparam int FD_SW = $bits(ecfl_pkg::cfl_side_t);

    // configuration
    logic [31:0] ts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ts_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // input register
    logic               accept;
    logic               in_vld_reg;
    ecfl_pkg::cell_in_t in_reg;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= cell_data;
        end
    end

    // momentum magnitude and its square, spacing, heat ratio clamp
    logic [31:0]        am_c;
    logic [63:0]        sq_c;
    logic signed [32:0] dxp_c, dxn_c, dx_c;
    logic               bad_c;
    logic [18:0]        g_c;

    always_comb
    begin
        am_c  = in_reg.momentum[31] ? (32'd0 - in_reg.momentum) : in_reg.momentum;
        sq_c  = am_c * am_c;
        dxp_c = {in_reg.x_right[31], in_reg.x_right} - {in_reg.x_here[31], in_reg.x_here};
        dxn_c = {in_reg.x_here[31], in_reg.x_here} - {in_reg.x_left[31], in_reg.x_left};
        dx_c  = (dxp_c < dxn_c) ? dxp_c : dxn_c;
        // zero density or a spacing that is not positive
        bad_c = (in_reg.density == 31'd0) || dx_c[32] || (dx_c == 33'sd0);
        g_c   = (in_reg.heat_ratio < ecfl_pkg::ONE_FX) ? ecfl_pkg::ONE_FX
                                                       : in_reg.heat_ratio;
    end

    logic        sq_vld_reg;
    logic [62:0] sq_reg;
    logic [30:0] sq_rho_reg;
    logic [31:0] sq_am_reg;
    logic [31:0] sq_en_reg;
    logic [18:0] sq_g_reg;
    logic [31:0] sq_dx_reg;
    logic        sq_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg <= 1'b0;
        end
        else
        begin
            sq_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg     <= sq_c[62:0];
        sq_rho_reg <= in_reg.density;
        sq_am_reg  <= am_c;
        sq_en_reg  <= in_reg.energy;
        sq_g_reg   <= g_c;
        sq_dx_reg  <= dx_c[31:0];
        sq_bad_reg <= bad_c;
    end

    // kinetic energy: ke = am^2 / (2 rho), only 31 quotient bits needed,
    // a larger ke leaves no positive pressure anyway
    ecfl_pkg::ke_side_t ka_head, ka_tail;
    logic               ka_vld  [0:ecfl_pkg::KE_LEN];
    logic [31:0]        ka_rem  [0:ecfl_pkg::KE_LEN];
    logic [30:0]        ka_num  [0:ecfl_pkg::KE_LEN];
    logic [31:0]        ka_den  [0:ecfl_pkg::KE_LEN];
    logic [KA_SW-1:0]   ka_side [0:ecfl_pkg::KE_LEN];

    always_comb
    begin
        ka_head.rho    = sq_rho_reg;
        ka_head.am     = sq_am_reg;
        ka_head.energy = sq_en_reg;
        ka_head.gamma  = sq_g_reg;
        ka_head.dx     = sq_dx_reg;
        ka_head.bad    = sq_bad_reg;
        ka_head.ke_big = (sq_reg[62:32] >= sq_rho_reg);
    end

    assign ka_vld[0]  = sq_vld_reg;
    assign ka_rem[0]  = sq_reg[62:31];
    assign ka_num[0]  = sq_reg[30:0];
    assign ka_den[0]  = {sq_rho_reg, 1'b0};
    assign ka_side[0] = ka_head;
    assign ka_tail    = ka_side[ecfl_pkg::KE_LEN];

    for (genvar i = 0; i < ecfl_pkg::KE_LEN; i++)
    begin : g_ke
        ecfl_div_cell #(.DEN_W(32), .NUM_W(31), .SIDE_W(KA_SW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (ka_vld[i]),
            .in_rem   (ka_rem[i]),
            .in_num   (ka_num[i]),
            .in_den   (ka_den[i]),
            .in_side  (ka_side[i]),
            .out_vld  (ka_vld[i+1]),
            .out_rem  (ka_rem[i+1]),
            .out_num  (ka_num[i+1]),
            .out_den  (ka_den[i+1]),
            .out_side (ka_side[i+1])
        );
    end

    // pressure times 2^16: (gamma - 1) * (energy - ke)
    logic [30:0] ke_w;
    logic        pos_c;
    logic [30:0] eint_c;
    logic [18:0] gm1_c;
    logic [49:0] pm_c;

    always_comb
    begin
        ke_w   = ka_num[ecfl_pkg::KE_LEN];
        pos_c  = !ka_tail.ke_big && !ka_tail.energy[31] && (ka_tail.energy[30:0] > ke_w);
        eint_c = ka_tail.energy[30:0] - ke_w;
        gm1_c  = ka_tail.gamma - ecfl_pkg::ONE_FX;
        pm_c   = gm1_c * eint_c;
    end

    logic        pm_vld_reg;
    logic [49:0] pm_reg;
    logic        pm_pos_reg;
    logic [30:0] pm_rho_reg;
    logic [31:0] pm_am_reg;
    logic [18:0] pm_g_reg;
    logic [31:0] pm_dx_reg;
    logic        pm_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_vld_reg <= 1'b0;
        end
        else
        begin
            pm_vld_reg <= ka_vld[ecfl_pkg::KE_LEN];
        end
    end

    always_ff @(posedge clk)
    begin
        pm_reg     <= pm_c;
        pm_pos_reg <= pos_c;
        pm_rho_reg <= ka_tail.rho;
        pm_am_reg  <= ka_tail.am;
        pm_g_reg   <= ka_tail.gamma;
        pm_dx_reg  <= ka_tail.dx;
        pm_bad_reg <= ka_tail.bad;
    end

    // gamma * pressure, clamped at zero pressure
    logic [33:0] pr_c;
    logic [52:0] gp_c;

    always_comb
    begin
        pr_c = pm_pos_reg ? pm_reg[49:ecfl_pkg::FRAC_BITS] : 34'd0;
        gp_c = pm_g_reg * pr_c;
    end

    logic        gp_vld_reg;
    logic [52:0] gp_reg;
    logic [30:0] gp_rho_reg;
    logic [31:0] gp_am_reg;
    logic [31:0] gp_dx_reg;
    logic        gp_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gp_vld_reg <= 1'b0;
        end
        else
        begin
            gp_vld_reg <= pm_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        gp_reg     <= gp_c;
        gp_rho_reg <= pm_rho_reg;
        gp_am_reg  <= pm_am_reg;
        gp_dx_reg  <= pm_dx_reg;
        gp_bad_reg <= pm_bad_reg;
    end

    // sound speed squared: c2 = gamma * pressure / rho
    ecfl_pkg::c2_side_t cb_head, cb_tail;
    logic               cb_vld  [0:ecfl_pkg::C2_LEN];
    logic [30:0]        cb_rem  [0:ecfl_pkg::C2_LEN];
    logic [52:0]        cb_num  [0:ecfl_pkg::C2_LEN];
    logic [30:0]        cb_den  [0:ecfl_pkg::C2_LEN];
    logic [CB_SW-1:0]   cb_side [0:ecfl_pkg::C2_LEN];

    always_comb
    begin
        cb_head.rho = gp_rho_reg;
        cb_head.am  = gp_am_reg;
        cb_head.dx  = gp_dx_reg;
        cb_head.bad = gp_bad_reg;
    end

    assign cb_vld[0]  = gp_vld_reg;
    assign cb_rem[0]  = 31'd0;
    assign cb_num[0]  = gp_reg;
    assign cb_den[0]  = gp_rho_reg;
    assign cb_side[0] = cb_head;
    assign cb_tail    = cb_side[ecfl_pkg::C2_LEN];

    for (genvar i = 0; i < ecfl_pkg::C2_LEN; i++)
    begin : g_c2
        ecfl_div_cell #(.DEN_W(31), .NUM_W(53), .SIDE_W(CB_SW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (cb_vld[i]),
            .in_rem   (cb_rem[i]),
            .in_num   (cb_num[i]),
            .in_den   (cb_den[i]),
            .in_side  (cb_side[i]),
            .out_vld  (cb_vld[i+1]),
            .out_rem  (cb_rem[i+1]),
            .out_num  (cb_num[i+1]),
            .out_den  (cb_den[i+1]),
            .out_side (cb_side[i+1])
        );
    end

    // sound speed: floor(sqrt(c2 * 2^16)), operand padded to an even width
    ecfl_pkg::c2_side_t sr_tail;
    logic               sr_vld  [0:ecfl_pkg::SQ_LEN];
    logic [36:0]        sr_rem  [0:ecfl_pkg::SQ_LEN];
    logic [69:0]        sr_op   [0:ecfl_pkg::SQ_LEN];
    logic [34:0]        sr_root [0:ecfl_pkg::SQ_LEN];
    logic [CB_SW-1:0]   sr_side [0:ecfl_pkg::SQ_LEN];

    assign sr_vld[0]  = cb_vld[ecfl_pkg::C2_LEN];
    assign sr_rem[0]  = 37'd0;
    assign sr_op[0]   = {1'b0, cb_num[ecfl_pkg::C2_LEN], 16'd0};
    assign sr_root[0] = 35'd0;
    assign sr_side[0] = cb_tail;
    assign sr_tail    = sr_side[ecfl_pkg::SQ_LEN];

    for (genvar i = 0; i < ecfl_pkg::SQ_LEN; i++)
    begin : g_sq
        ecfl_sqrt_cell #(.OP_W(70), .ROOT_W(35), .SIDE_W(CB_SW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (sr_vld[i]),
            .in_rem   (sr_rem[i]),
            .in_op    (sr_op[i]),
            .in_root  (sr_root[i]),
            .in_side  (sr_side[i]),
            .out_vld  (sr_vld[i+1]),
            .out_rem  (sr_rem[i+1]),
            .out_op   (sr_op[i+1]),
            .out_root (sr_root[i+1]),
            .out_side (sr_side[i+1])
        );
    end

    // velocity magnitude: (am << 16) / rho
    ecfl_pkg::vel_side_t vc_head, vc_tail;
    logic                vc_vld  [0:ecfl_pkg::VEL_LEN];
    logic [30:0]         vc_rem  [0:ecfl_pkg::VEL_LEN];
    logic [47:0]         vc_num  [0:ecfl_pkg::VEL_LEN];
    logic [30:0]         vc_den  [0:ecfl_pkg::VEL_LEN];
    logic [VC_SW-1:0]    vc_side [0:ecfl_pkg::VEL_LEN];

    always_comb
    begin
        vc_head.snd = sr_root[ecfl_pkg::SQ_LEN];
        vc_head.dx  = sr_tail.dx;
        vc_head.bad = sr_tail.bad;
    end

    assign vc_vld[0]  = sr_vld[ecfl_pkg::SQ_LEN];
    assign vc_rem[0]  = 31'd0;
    assign vc_num[0]  = {sr_tail.am, 16'd0};
    assign vc_den[0]  = sr_tail.rho;
    assign vc_side[0] = vc_head;
    assign vc_tail    = vc_side[ecfl_pkg::VEL_LEN];

    for (genvar i = 0; i < ecfl_pkg::VEL_LEN; i++)
    begin : g_vel
        ecfl_div_cell #(.DEN_W(31), .NUM_W(48), .SIDE_W(VC_SW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (vc_vld[i]),
            .in_rem   (vc_rem[i]),
            .in_num   (vc_num[i]),
            .in_den   (vc_den[i]),
            .in_side  (vc_side[i]),
            .out_vld  (vc_vld[i+1]),
            .out_rem  (vc_rem[i+1]),
            .out_num  (vc_num[i+1]),
            .out_den  (vc_den[i+1]),
            .out_side (vc_side[i+1])
        );
    end

    // wave speed
    logic        ws_vld_reg;
    logic [48:0] ws_reg;
    logic [31:0] ws_dx_reg;
    logic        ws_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_vld_reg <= 1'b0;
        end
        else
        begin
            ws_vld_reg <= vc_vld[ecfl_pkg::VEL_LEN];
        end
    end

    always_ff @(posedge clk)
    begin
        ws_reg     <= {14'd0, vc_tail.snd} + {1'b0, vc_num[ecfl_pkg::VEL_LEN]};
        ws_dx_reg  <= vc_tail.dx;
        ws_bad_reg <= vc_tail.bad;
    end

    // time_step * wave speed, split in two partial products
    logic        pp_vld_reg;
    logic [56:0] pp_lo_reg;
    logic [55:0] pp_hi_reg;
    logic [31:0] pp_dx_reg;
    logic        pp_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_vld_reg <= 1'b0;
        end
        else
        begin
            pp_vld_reg <= ws_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pp_lo_reg  <= ts_reg * ws_reg[24:0];
        pp_hi_reg  <= ts_reg * ws_reg[48:25];
        pp_dx_reg  <= ws_dx_reg;
        pp_bad_reg <= ws_bad_reg;
    end

    logic        nm_vld_reg;
    logic [80:0] nm_reg;
    logic [31:0] nm_dx_reg;
    logic        nm_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_vld_reg <= 1'b0;
        end
        else
        begin
            nm_vld_reg <= pp_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        nm_reg     <= {pp_hi_reg, 25'd0} + {24'd0, pp_lo_reg};
        nm_dx_reg  <= pp_dx_reg;
        nm_bad_reg <= pp_bad_reg;
    end

    // cfl = (ts * w) / (2 dx); a quotient of 2^32 or more saturates
    ecfl_pkg::cfl_side_t fd_head, fd_tail;
    logic                fd_vld  [0:ecfl_pkg::CFL_LEN];
    logic [32:0]         fd_rem  [0:ecfl_pkg::CFL_LEN];
    logic [31:0]         fd_num  [0:ecfl_pkg::CFL_LEN];
    logic [32:0]         fd_den  [0:ecfl_pkg::CFL_LEN];
    logic [FD_SW-1:0]    fd_side [0:ecfl_pkg::CFL_LEN];

    always_comb
    begin
        fd_head.sat = (nm_reg[80:32] >= {16'd0, nm_dx_reg, 1'b0});
        fd_head.bad = nm_bad_reg;
    end

    assign fd_vld[0]  = nm_vld_reg;
    assign fd_rem[0]  = nm_reg[64:32];
    assign fd_num[0]  = nm_reg[31:0];
    assign fd_den[0]  = {nm_dx_reg, 1'b0};
    assign fd_side[0] = fd_head;
    assign fd_tail    = fd_side[ecfl_pkg::CFL_LEN];

    for (genvar i = 0; i < ecfl_pkg::CFL_LEN; i++)
    begin : g_cfl
        ecfl_div_cell #(.DEN_W(33), .NUM_W(32), .SIDE_W(FD_SW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (fd_vld[i]),
            .in_rem   (fd_rem[i]),
            .in_num   (fd_num[i]),
            .in_den   (fd_den[i]),
            .in_side  (fd_side[i]),
            .out_vld  (fd_vld[i+1]),
            .out_rem  (fd_rem[i+1]),
            .out_num  (fd_num[i+1]),
            .out_den  (fd_den[i+1]),
            .out_side (fd_side[i+1])
        );
    end

    // output register, bad data wins over saturation
    logic              done_reg;
    ecfl_pkg::result_t res_reg, res_next;

    always_comb
    begin
        priority if (fd_tail.bad)
        begin
            res_next.cfl    = 32'd0;
            res_next.status = ecfl_pkg::ST_BAD;
        end
        else if (fd_tail.sat)
        begin
            res_next.cfl    = ecfl_pkg::CFL_MAX;
            res_next.status = ecfl_pkg::ST_SAT;
        end
        else
        begin
            res_next.cfl    = fd_num[ecfl_pkg::CFL_LEN];
            res_next.status = ecfl_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fd_vld[ecfl_pkg::CFL_LEN];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[rtl/ecfl_checker.sv]
`include "assert_macros.svh"

module ecfl_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input ecfl_pkg::result_t result
);

    // every result traces back to an accepted item a fixed latency earlier
    `ECFL_ASSERT_IMP(a_done_latency, done, $past(start && !busy, ecfl_pkg::LATENCY), "result without item")
    `ECFL_ASSERT_NEVER(a_status_code, done && !(result.status == ecfl_pkg::ST_OK || result.status == ecfl_pkg::ST_SAT || result.status == ecfl_pkg::ST_BAD), "unknown status")
    // bad data gives a zero cfl
    `ECFL_ASSERT_IMP(a_bad_zero, done && result.status == ecfl_pkg::ST_BAD, result.cfl == 32'd0, "bad item with nonzero cfl")
    // saturation shows the largest value
    `ECFL_ASSERT_IMP(a_sat_max, done && result.status == ecfl_pkg::ST_SAT, result.cfl == ecfl_pkg::CFL_MAX, "saturated cfl not at maximum")

endmodule

bind euler_cell_cfl_number ecfl_checker u_ecfl_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
